FILE: design/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// mbrc_pkg: shared definitions for the Modbus RTU response checker
// Action and status codes, field widths, and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mbrc_pkg;

    // Request kinds carried on the input channel.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Transaction status codes.
    localparam logic [2:0] ST_READY        = 3'd0;
    localparam logic [2:0] ST_WAITING      = 3'd1;
    localparam logic [2:0] ST_SUCCESS      = 3'd2;
    localparam logic [2:0] ST_TIMEOUT      = 3'd3;
    localparam logic [2:0] ST_BAD_SLAVE    = 3'd4;
    localparam logic [2:0] ST_BAD_FUNCTION = 3'd5;
    localparam logic [2:0] ST_EXCEPTION    = 3'd6;
    localparam logic [2:0] ST_BAD_CRC      = 3'd7;

    // Configuration register indexes.
    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FIXED_LENGTH  = 8'd3;
    localparam logic [7:0]  START_LENGTH  = 8'd8;
    localparam logic [8:0]  HEADER_END    = 9'd5;
    localparam logic [6:0]  FUNC_READ_REG = 7'd3;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [15:0] WORD_MISSING  = 16'hFFFF;

    typedef logic [7:0] byte_t;

    // One byte through the reflected CRC-16, bit by bit.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input byte_t b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: design/modbus_rtu_response_checker_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_top: master-side Modbus RTU response checker
// Checks a slave response byte by byte and keeps the committed data words.
// ----------------------------------------------------------------------------
// A start request arms the checker with the function code of the request just
// sent; byte requests then feed the response in order, tick requests advance
// the timeout, and read requests fetch a committed data word. Every request
// yields exactly one result, which carries the status after that request, the
// exception code, the word read and a finished flag; the finished flag travels
// as m_tlast and marks the result that closed the transaction. The block takes
// one request per clock cycle without gaps while m_tready keeps up: a request
// is captured in the input register, processed there by the state logic, and
// its result is registered in the result register. The data words live in a
// two-bank word memory with one bank bit per slot; a good function-3 response
// commits its words by flipping the bank bits of the committed slots, and reads
// go through the registered memory read port. The CRC update folds one byte
// per request through eight shift steps. After reset the block is ready at
// once and all in-range words read as zero.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_top
    import mbrc_pkg::*;
#(
    parameter int WORD_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from the lowest up: expected_function[6:0], rx_byte[14:7],
    // word_index[22:15], zero fill [23].
    input  logic [23:0] s_tdata,
    // Bits from the lowest up: action[1:0].
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from the lowest up: status[2:0], exception_code[10:3],
    // read_word[26:11], zero fill [31:27].
    output logic [31:0] m_tdata,
    // High on the result that finished the transaction.
    output logic        m_tlast
);

    // Slot index width and memory geometry: address is {bank, slot}.
    localparam int SLOT_W    = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int MEM_DEPTH = 2 ** (SLOT_W + 1);
    localparam logic [8:0] SLOTS_LIMIT = 9'(WORD_SLOTS);

    // Configuration registers.
    logic [7:0]  slave_address_reg;
    logic [15:0] timeout_ticks_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [6:0]  in_function_reg;
    byte_t       in_byte_reg;
    logic [7:0]  in_index_reg;

    // Transaction state.
    logic [2:0]  status_reg,      status_next;
    byte_t       exc_value_reg,   exc_value_next;
    logic [6:0]  func_exp_reg,    func_exp_next;
    logic [15:0] tick_count_reg,  tick_count_next;
    logic [8:0]  bytes_rcv_reg,   bytes_rcv_next;
    logic [7:0]  bytes_left_reg,  bytes_left_next;
    logic [15:0] crc_reg,         crc_next;
    byte_t       held_reg [2];
    byte_t       held_next [2];
    byte_t       header_reg [3];
    byte_t       header_next [3];
    byte_t       pending_reg,     pending_next;

    // Per-slot bank select of the committed copy, and per-slot written marks.
    logic [WORD_SLOTS-1:0] cbank_reg, cbank_next;
    logic [WORD_SLOTS-1:0] valid_reg, valid_next;

    // Word memory, two banks.
    logic [15:0]       mem [MEM_DEPTH];
    logic [15:0]       mem_rdata_reg;
    logic              mem_we;
    logic [SLOT_W:0]   mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [SLOT_W:0]   mem_raddr;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    byte_t       out_exc_reg;
    logic [15:0] out_word_reg;
    logic        out_use_mem_reg;
    logic        out_finished_reg;

    logic        advance;
    logic        done;
    logic [15:0] word_value;
    logic        use_mem;

    // Helper values for a received byte.
    logic [8:0]        pos;
    logic [8:0]        data_pos;
    logic [7:0]        word_pos;
    logic              word_in_range;
    logic [SLOT_W-1:0] word_slot;
    logic [15:0]       crc_after;
    logic [15:0]       tick_inc;
    logic              read_in_range;
    logic [SLOT_W-1:0] read_slot;
    logic [6:0]        commit_count;

    // The request in the input register moves on whenever the result register
    // is free or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pos           = bytes_rcv_reg;
    assign data_pos      = pos - 9'd3;
    assign word_pos      = data_pos[8:1];
    assign word_in_range = {1'b0, word_pos} < SLOTS_LIMIT;
    assign word_slot     = word_pos[SLOT_W-1:0];
    assign crc_after     = (pos >= 9'd2) ? crc_fold(crc_reg, held_reg[0]) : crc_reg;
    assign tick_inc      = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                        : tick_count_reg + 16'd1;
    assign read_in_range = {1'b0, in_index_reg} < SLOTS_LIMIT;
    assign read_slot     = in_index_reg[SLOT_W-1:0];

    always_comb begin
        status_next     = status_reg;
        exc_value_next  = exc_value_reg;
        func_exp_next   = func_exp_reg;
        tick_count_next = tick_count_reg;
        bytes_rcv_next  = bytes_rcv_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        held_next       = held_reg;
        header_next     = header_reg;
        pending_next    = pending_reg;
        cbank_next      = cbank_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = {~cbank_reg[word_slot], word_slot};
        mem_wdata       = {pending_reg, in_byte_reg};
        mem_re          = 1'b0;
        mem_raddr       = {cbank_reg[read_slot], read_slot};
        done            = 1'b0;
        word_value      = 16'd0;
        use_mem         = 1'b0;
        commit_count    = header_reg[2][7:1];

        unique case (in_action_reg)
            ACT_START: begin
                func_exp_next   = in_function_reg;
                tick_count_next = 16'd0;
                bytes_rcv_next  = 9'd0;
                bytes_left_next = START_LENGTH;
                crc_next        = CRC_SEED;
                held_next[0]    = 8'd0;
                held_next[1]    = 8'd0;
                header_next[0]  = 8'd0;
                header_next[1]  = 8'd0;
                header_next[2]  = 8'd0;
                pending_next    = 8'd0;
                exc_value_next  = 8'd0;
                status_next     = ST_WAITING;
            end
            ACT_BYTE: begin
                if (status_reg == ST_WAITING) begin
                    crc_next     = crc_after;
                    held_next[0] = held_reg[1];
                    held_next[1] = in_byte_reg;
                    if (pos < 9'd3) begin
                        header_next[pos[1:0]] = in_byte_reg;
                    end else if (!data_pos[0]) begin
                        pending_next = in_byte_reg;
                    end else if (word_in_range) begin
                        mem_we = advance;
                    end
                    bytes_rcv_next  = pos + 9'd1;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    commit_count    = header_next[2][7:1];

                    // Header check after the fifth byte, with address, function and count in place.
                    if (bytes_rcv_next == HEADER_END) begin
                        priority if (header_next[0] != slave_address_reg) begin
                            status_next = ST_BAD_SLAVE;
                            done        = 1'b1;
                        end else if (header_next[1][6:0] != func_exp_reg) begin
                            status_next = ST_BAD_FUNCTION;
                            done        = 1'b1;
                        end else if (header_next[1][7]) begin
                            exc_value_next = header_next[2];
                            status_next    = ST_EXCEPTION;
                            done           = 1'b1;
                        end else if (header_next[1] == {1'b0, FUNC_READ_REG}) begin
                            bytes_left_next = header_next[2];
                        end else begin
                            bytes_left_next = FIXED_LENGTH;
                        end
                    end

                    // End of frame: the two held bytes are the CRC, low first.
                    if (!done && bytes_left_next == 8'd0 && bytes_rcv_next >= HEADER_END) begin
                        done = 1'b1;
                        if (crc_after[7:0] != held_next[0] ||
                            crc_after[15:8] != held_next[1]) begin
                            status_next = ST_BAD_CRC;
                        end else begin
                            status_next = ST_SUCCESS;
                            if (header_next[1] == {1'b0, FUNC_READ_REG}) begin
                                for (int i = 0; i < WORD_SLOTS; i++) begin
                                    if (i < int'(commit_count)) begin
                                        cbank_next[i] = ~cbank_reg[i];
                                        valid_next[i] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (status_reg == ST_WAITING) begin
                    tick_count_next = tick_inc;
                    if (tick_inc > timeout_ticks_reg) begin
                        status_next = ST_TIMEOUT;
                        done        = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                if (!read_in_range) begin
                    word_value = WORD_MISSING;
                end else if (valid_reg[read_slot]) begin
                    use_mem = 1'b1;
                    mem_re  = advance;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= 8'd1;
            timeout_ticks_reg <= 16'd500;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_action_reg   <= s_tuser;
            in_function_reg <= s_tdata[6:0];
            in_byte_reg     <= s_tdata[14:7];
            in_index_reg    <= s_tdata[22:15];
        end
    end

    // Transaction state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= ST_READY;
            exc_value_reg  <= 8'd0;
            func_exp_reg   <= 7'd0;
            tick_count_reg <= 16'd0;
            bytes_rcv_reg  <= 9'd0;
            bytes_left_reg <= START_LENGTH;
            crc_reg        <= CRC_SEED;
            held_reg[0]    <= 8'd0;
            held_reg[1]    <= 8'd0;
            header_reg[0]  <= 8'd0;
            header_reg[1]  <= 8'd0;
            header_reg[2]  <= 8'd0;
            pending_reg    <= 8'd0;
            cbank_reg      <= '0;
            valid_reg      <= '0;
        end else if (advance) begin
            status_reg     <= status_next;
            exc_value_reg  <= exc_value_next;
            func_exp_reg   <= func_exp_next;
            tick_count_reg <= tick_count_next;
            bytes_rcv_reg  <= bytes_rcv_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            held_reg       <= held_next;
            header_reg     <= header_next;
            pending_reg    <= pending_next;
            cbank_reg      <= cbank_next;
            valid_reg      <= valid_next;
        end
    end

    // Word memory: staging writes go to the bank not holding the committed copy.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_status_reg   <= status_next;
            out_exc_reg      <= (status_next == ST_EXCEPTION) ? exc_value_next : 8'd0;
            out_word_reg     <= word_value;
            out_use_mem_reg  <= use_mem;
            out_finished_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_finished_reg;
    assign m_tdata  = {5'd0,
                       out_use_mem_reg ? mem_rdata_reg : out_word_reg,
                       out_exc_reg, out_status_reg};

    // A finished result always carries a final status.
    a_finished_final: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_finished_reg |->
            out_status_reg != ST_READY && out_status_reg != ST_WAITING)
        else $error("finished result without a final status");

    // An exception code is only reported with the exception status.
    a_exc_only_on_exception: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_exc_reg != 8'd0 |-> out_status_reg == ST_EXCEPTION)
        else $error("exception code reported with another status");

    // The input side only stalls when both stages hold a request and the
    // result is not being taken.
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    // A processed start always leaves the checker waiting.
    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_action_reg == ACT_START |=> status_reg == ST_WAITING)
        else $error("start did not arm the checker");

endmodule
